FILE: rtl/mi_pkg.sv
// Shared widths, fixed-point constants and the bar record for the mass index block.
package mi_pkg;

    localparam int PRICE_W     = 32;  // Q16.16 prices and range
    localparam int FRAC_W      = 16;  // fraction bits of prices, ratios and sums
    localparam int RATIO_INT_W = 8;   // integer bits of the Q8.16 ratio
    localparam int RATIO_W     = 24;  // Q8.16 ratio
    localparam int EMA_W       = 48;  // Q16.32 moving averages
    localparam int SUM_W       = 30;  // Q14.16 running sum
    localparam int PERIOD_W    = 7;   // width of the sum period register
    localparam int BAR_W       = 11;  // bar index, covers every legal parameter setting
    localparam int COEF_W      = 16;  // smoothing coefficient width
    localparam int PROD_W      = 64;  // product and accumulator width
    localparam int QUEUE_DEPTH = 2;   // requests held between front and back

    localparam logic [COEF_W-1:0]   ALPHA_Q16           = 16'd13107;
    localparam logic [COEF_W-1:0]   ONE_MINUS_ALPHA_Q16 = 16'd52429;
    localparam logic [PROD_W-1:0]   ROUND_HALF          = 64'd32768;
    localparam logic [RATIO_W-1:0]  RATIO_MAX           = {RATIO_W{1'b1}};
    localparam logic [SUM_W-1:0]    SUM_MAX             = {SUM_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_RESET        = 7'd25;

    // One classified bar as it travels from the front to the back.
    typedef struct packed {
        logic               first;
        logic [PRICE_W-1:0] bar_range;
        logic [BAR_W-1:0]   idx;
    } mi_bar_t;

endpackage

FILE: rtl/mass_index_stream.sv
// Top level of the mass index stream: configuration register, front end, queue, back end, divider.
// Path of a bar that yields a result: the queue, the two EMA updates, the clamp check, the
//   24-step divider (skipped when the ratio saturates), the ring update and the result register.
//   The back end finishes one bar before it takes the next from the queue; bars before the seed
//   bar run only the first EMA update, and later bars before the start bar run only the two EMA updates.
// Reset (aresetn low, synchronous) clears both EMAs, the sum, pointer, bar count, queue and
//   output valid, and sets the period to 25; the ratio ring is not cleared and needs no sweep.
module mass_index_stream #(
    parameter int MAX_PERIOD = 64,
    parameter int EMA_LENGTH = 9
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Bar requests.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_first_bar,
    input  logic [mi_pkg::PRICE_W-1:0]   s_high_price,
    input  logic [mi_pkg::PRICE_W-1:0]   s_low_price,
    // Mass index results.
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mi_pkg::SUM_W-1:0]     m_mass_value,
    output logic                         m_ratio_clamped,
    // Sum period register.
    input  logic                         cfg_wr_en,
    input  logic [mi_pkg::PERIOD_W-1:0]  cfg_wr_data
);
    import mi_pkg::*;

    localparam int PER_W = $clog2(MAX_PERIOD + 1);

    logic [PERIOD_W-1:0] sum_period_reg;
    logic [PERIOD_W-1:0] sum_period_next;
    logic [PER_W-1:0]    period_eff;

    mi_bar_t          push_entry;
    mi_bar_t          pop_entry;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;

    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [EMA_W-1:0] div_num;
    logic [EMA_W-1:0] div_den;
    logic [RATIO_W-1:0] div_quot;

    // The period register must be written only while the block is idle, so the back
    // end may read it directly; the block itself does not enforce this. A zero period
    // behaves as one, and anything above the ring depth behaves as the ring depth.
    assign sum_period_next = cfg_wr_en ? cfg_wr_data : sum_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_period_reg <= PERIOD_RESET;
        end else begin
            sum_period_reg <= sum_period_next;
        end
    end

    always_comb begin
        if (sum_period_reg == '0) begin
            period_eff = PER_W'(1);
        end else if (32'(sum_period_reg) > MAX_PERIOD) begin
            period_eff = PER_W'(MAX_PERIOD);
        end else begin
            period_eff = PER_W'(sum_period_reg);
        end
    end

    // The front end computes the bar range and its index in the series. It keeps
    // taking requests as long as the queue has room, independent of the back end.
    mi_front #(
        .EMA_LENGTH (EMA_LENGTH),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_first_bar  (s_first_bar),
        .s_high_price (s_high_price),
        .s_low_price  (s_low_price),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (push_entry)
    );

    mi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // The back end runs the EMA updates on one shared multiplier, forms the ratio,
    // maintains the ring and its running sum, and holds the result register so a
    // waiting result does not stop the next bar from starting.
    mi_back #(
        .EMA_LENGTH (EMA_LENGTH),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_entry         (pop_entry),
        .q_pop           (q_pop),
        .period          (period_eff),
        .div_start       (div_start),
        .div_num         (div_num),
        .div_den         (div_den),
        .div_done        (div_done),
        .div_quot        (div_quot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mass_value    (m_mass_value),
        .m_ratio_clamped (m_ratio_clamped)
    );

    mi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

`ifndef SYNTHESIS
    a_div_idle_without_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |=> !div_busy) else $error("divider busy right after finishing");
`endif

endmodule

FILE: rtl/mi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/mi_front.sv
// Front end: takes bar requests, forms the range and assigns each bar its index.
module mi_front #(
    parameter int EMA_LENGTH = 9,
    parameter int MAX_PERIOD = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_first_bar,
    input  logic [mi_pkg::PRICE_W-1:0]    s_high_price,
    input  logic [mi_pkg::PRICE_W-1:0]    s_low_price,
    input  logic                          q_full,
    output logic                          q_push,
    output mi_pkg::mi_bar_t               q_entry
);
    import mi_pkg::*;

    localparam int BAR_CAP = 2 * (EMA_LENGTH - 1) + MAX_PERIOD;

    logic [BAR_W-1:0] bar_count_reg;
    logic [BAR_W-1:0] bar_count_next;
    logic [BAR_W-1:0] idx;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // A first bar restarts the series at index zero.
    assign idx = s_first_bar ? '0 : bar_count_reg;

    always_comb begin
        bar_count_next = bar_count_reg;
        if (q_push) begin
            bar_count_next = (idx < BAR_W'(BAR_CAP)) ? idx + 1'b1 : idx;
        end
    end

    always_comb begin
        q_entry.first     = s_first_bar;
        q_entry.bar_range = (s_high_price >= s_low_price) ? s_high_price - s_low_price : '0;
        q_entry.idx       = idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_count_reg <= '0;
        end else begin
            bar_count_reg <= bar_count_next;
        end
    end

endmodule

FILE: rtl/mi_queue.sv
// Short request queue that decouples the front end from the back end.
module mi_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mi_pkg::mi_bar_t push_entry,
    input  logic            pop,
    output mi_pkg::mi_bar_t pop_entry,
    output logic            full,
    output logic            empty
);
    import mi_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mi_bar_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/mi_div.sv
// Radix-2 restoring divider giving the Q8.16 ratio of two moving averages.
module mi_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mi_pkg::EMA_W-1:0]    num,
    input  logic [mi_pkg::EMA_W-1:0]    den,
    output logic                        busy,
    output logic                        done,
    output logic [mi_pkg::RATIO_W-1:0]  quot
);
    import mi_pkg::*;

    localparam int CNT_W = $clog2(RATIO_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [EMA_W-1:0]   rem_reg, rem_next;
    logic [EMA_W-1:0]   den_reg, den_next;
    logic [RATIO_W-1:0] low_reg, low_next;
    logic [RATIO_W-1:0] quot_reg, quot_next;
    logic [EMA_W:0]     trial;
    logic               trial_ge;

    // The caller guarantees num < den * 2^8, so the quotient fits in RATIO_W
    // bits and the remainder after the upper dividend bits is num >> 8.
    assign trial    = {rem_reg, low_reg[RATIO_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RATIO_W - 1);
            rem_next  = num >> RATIO_INT_W;
            den_next  = den;
            low_next  = {num[RATIO_INT_W-1:0], {FRAC_W{1'b0}}};
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = trial_ge ? EMA_W'(trial - {1'b0, den_reg}) : trial[EMA_W-1:0];
            quot_next = {quot_reg[RATIO_W-2:0], trial_ge};
            low_next  = {low_reg[RATIO_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
`endif

endmodule

FILE: rtl/mi_back.sv
// Back end: EMA updates, ratio, ring of ratios with running sum, and the result register.
module mi_back #(
    parameter int EMA_LENGTH = 9,
    parameter int MAX_PERIOD = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  mi_pkg::mi_bar_t                     q_entry,
    output logic                                q_pop,
    input  logic [$clog2(MAX_PERIOD + 1)-1:0]   period,
    output logic                                div_start,
    output logic [mi_pkg::EMA_W-1:0]            div_num,
    output logic [mi_pkg::EMA_W-1:0]            div_den,
    input  logic                                div_done,
    input  logic [mi_pkg::RATIO_W-1:0]          div_quot,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mi_pkg::SUM_W-1:0]            m_mass_value,
    output logic                                m_ratio_clamped
);
    import mi_pkg::*;

    localparam int PER_W     = $clog2(MAX_PERIOD + 1);
    localparam int PTR_W     = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int SEED_BAR  = EMA_LENGTH - 1;
    localparam int START_BAR = 2 * (EMA_LENGTH - 1);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_E1_M0 = 12'b0000_0000_0010,
        ST_E1_M1 = 12'b0000_0000_0100,
        ST_E1_M2 = 12'b0000_0000_1000,
        ST_E2_M0 = 12'b0000_0001_0000,
        ST_E2_M1 = 12'b0000_0010_0000,
        ST_E2_M2 = 12'b0000_0100_0000,
        ST_CHECK = 12'b0000_1000_0000,
        ST_DIV   = 12'b0001_0000_0000,
        ST_SUB   = 12'b0010_0000_0000,
        ST_ADD   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } mi_state_t;

    mi_state_t          state_reg, state_next;
    logic [PRICE_W-1:0] range_reg, range_next;
    logic [BAR_W-1:0]   idx_reg, idx_next;
    logic [EMA_W-1:0]   ema1_reg, ema1_next;
    logic [EMA_W-1:0]   ema2_reg, ema2_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic               clamp_reg, clamp_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic               m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]   m_mass_reg, m_mass_next;
    logic               m_clamp_reg, m_clamp_next;

    logic [EMA_W-1:0]   mul_a;
    logic [COEF_W-1:0]  mul_b;
    logic [EMA_W-1:0]   ema_new;
    logic [EMA_W-1:0]   x_q32;
    logic [BAR_W-1:0]   held;
    logic [PTR_W-1:0]   ptr_wrap;
    logic [PER_W-1:0]   ptr_inc;
    logic [SUM_W:0]     sum_add;
    logic               ratio_clamp;
    logic               ram_rd_en;
    logic               ram_wr_en;
    logic [RATIO_W-1:0] ram_rd_data;

    assign x_q32    = {range_reg, {FRAC_W{1'b0}}};
    assign ema_new  = EMA_W'((acc_reg + prod_reg) >> FRAC_W);
    assign held     = idx_reg - BAR_W'(START_BAR);
    assign ptr_wrap = (PER_W'(ptr_reg) >= period) ? '0 : ptr_reg;
    assign ptr_inc  = PER_W'(ptr_reg) + 1'b1;
    assign sum_add  = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(ratio_reg);

    // Saturate when the divisor is zero or the quotient would need more than 8 integer bits.
    assign ratio_clamp = (ema2_reg == '0) ||
                         ((EMA_W + RATIO_INT_W)'(ema1_reg) >= {ema2_reg, {RATIO_INT_W{1'b0}}});

    assign div_num   = ema1_reg;
    assign div_den   = ema2_reg;
    assign div_start = (state_reg == ST_CHECK) && !ratio_clamp;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign ram_rd_en = (state_reg == ST_CHECK);
    assign ram_wr_en = (state_reg == ST_SUB);

    always_comb begin
        case (state_reg)
            ST_E1_M0: begin
                mul_a = ema1_reg;
                mul_b = ONE_MINUS_ALPHA_Q16;
            end
            ST_E1_M1: begin
                mul_a = x_q32;
                mul_b = ALPHA_Q16;
            end
            ST_E2_M0: begin
                mul_a = ema2_reg;
                mul_b = ONE_MINUS_ALPHA_Q16;
            end
            ST_E2_M1: begin
                mul_a = ema1_reg;
                mul_b = ALPHA_Q16;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        state_next   = state_reg;
        range_next   = range_reg;
        idx_next     = idx_reg;
        ema1_next    = ema1_reg;
        ema2_next    = ema2_reg;
        acc_next     = acc_reg;
        ratio_next   = ratio_reg;
        clamp_next   = clamp_reg;
        sum_next     = sum_reg;
        ptr_next     = ptr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_mass_next  = m_mass_reg;
        m_clamp_next = m_clamp_reg;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    range_next = q_entry.bar_range;
                    idx_next   = q_entry.idx;
                    if (q_entry.first) begin
                        ema1_next = {q_entry.bar_range, {FRAC_W{1'b0}}};
                        ema2_next = {q_entry.bar_range, {FRAC_W{1'b0}}};
                        sum_next  = '0;
                        ptr_next  = '0;
                    end
                    state_next = ST_E1_M0;
                end
            end
            ST_E1_M0: begin
                state_next = ST_E1_M1;
            end
            ST_E1_M1: begin
                acc_next   = prod_reg + ROUND_HALF;
                state_next = ST_E1_M2;
            end
            ST_E1_M2: begin
                ema1_next = ema_new;
                if (idx_reg == BAR_W'(SEED_BAR)) begin
                    ema2_next = ema_new;
                end
                state_next = (idx_reg < BAR_W'(SEED_BAR)) ? ST_IDLE : ST_E2_M0;
            end
            ST_E2_M0: begin
                state_next = ST_E2_M1;
            end
            ST_E2_M1: begin
                acc_next   = prod_reg + ROUND_HALF;
                state_next = ST_E2_M2;
            end
            ST_E2_M2: begin
                ema2_next  = ema_new;
                state_next = (idx_reg < BAR_W'(START_BAR)) ? ST_IDLE : ST_CHECK;
            end
            ST_CHECK: begin
                ptr_next   = ptr_wrap;
                clamp_next = ratio_clamp;
                if (ratio_clamp) begin
                    ratio_next = RATIO_MAX;
                    state_next = ST_SUB;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    ratio_next = div_quot;
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                // Once the ring is full, the entry about to be overwritten leaves the sum.
                if (held >= BAR_W'(period)) begin
                    sum_next = (sum_reg >= SUM_W'(ram_rd_data)) ?
                               sum_reg - SUM_W'(ram_rd_data) : '0;
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                ptr_next   = (ptr_inc >= period) ? '0 : PTR_W'(ptr_inc);
                state_next = (held >= BAR_W'(period - 1'b1)) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_mass_next  = sum_reg;
                    m_clamp_next = clamp_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        range_reg   <= range_next;
        idx_reg     <= idx_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        ratio_reg   <= ratio_next;
        clamp_reg   <= clamp_next;
        m_mass_reg  <= m_mass_next;
        m_clamp_reg <= m_clamp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ema1_reg    <= '0;
            ema2_reg    <= '0;
            sum_reg     <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ema1_reg    <= ema1_next;
            ema2_reg    <= ema2_next;
            sum_reg     <= sum_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    mi_ram #(
        .WIDTH (RATIO_W),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (ratio_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_wrap),
        .rd_data (ram_rd_data)
    );

    assign m_valid         = m_valid_reg;
    assign m_mass_value    = m_mass_reg;
    assign m_ratio_clamped = m_clamp_reg;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV) else $error("divider finished outside ST_DIV");
    a_ring_only_late_bars: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUB |-> idx_reg >= BAR_W'(START_BAR))
        else $error("ring updated for an early bar");
`endif

endmodule
